@@ hdl/swrr_pkg.sv @@
// Package for the smooth weighted round-robin path selector.
// Table sizes, payload structs, FSM state type and register map.
// No dependencies.
package swrr_pkg;

	localparam int MAX_PATHS = 8;
	localparam int IDX_W = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
	localparam int CNT_W = $clog2(MAX_PATHS + 1);
	localparam int WGT_W = 32;
	localparam int TOTAL_W = 24;
	localparam int THR_W = 4;
	localparam logic [THR_W-1:0] THR_RESET = 4'd3;
	localparam logic REG_TIMEOUT_THR = 1'b0;

	typedef struct packed {
		logic [7:0]  path_id;
		logic [15:0] weight;
		logic        path_active;
		logic        path_frozen;
		logic        socket_error;
		logic [3:0]  timeout_count;
		logic        can_send;
		logic [31:0] smoothed_rtt;
		logic        control_packet;
		logic        reinject;
		logic [7:0]  packet_path_id;
		logic        last_path;
	} item_t;

	typedef struct packed {
		logic       selected_valid;
		logic [7:0] selected_path_id;
		logic       send_blocked;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPD,
		ST_CRD,
		ST_CWR,
		ST_EMIT
	} state_t;

endpackage

@@ hdl/swrr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swrr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/smooth_weighted_round_robin_path_select.sv @@
// Smooth weighted round-robin path selector, top level.
// An item is captured, then looked up in the table with a weight RAM read, then accrued and
// written back. A data pass end then compacts the table through the weight RAM, reading each
// slot and writing the kept ones back in turn, then emits; a control pass end goes straight to emit.
// Emit waits while the previous result is not taken. A new item is accepted only when idle.
// Reset: threshold 3, table empty, pass scratch cleared; no RAM clearing pass.
// Depends on swrr_pkg and swrr_ram.
module smooth_weighted_round_robin_path_select (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  swrr_pkg::item_t       item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output swrr_pkg::result_t     result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int N = swrr_pkg::MAX_PATHS;
	localparam int IW = swrr_pkg::IDX_W;
	localparam int CW = swrr_pkg::CNT_W;
	localparam int WW = swrr_pkg::WGT_W;
	localparam int TW = swrr_pkg::TOTAL_W;

	swrr_pkg::state_t state_q, state_d;
	swrr_pkg::item_t  item_q;
	logic [swrr_pkg::THR_W-1:0] thr_q;

	logic [7:0]    pid_q [N];
	logic [N-1:0]  seen_q;
	logic [CW-1:0] count_q;
	logic [TW-1:0] total_q;
	logic [IW-1:0] best_slot_q;
	logic [7:0]    best_path_q;
	logic          best_found_q;
	logic [31:0]   best_rtt_q;
	logic [WW-1:0] best_weight_q;
	logic          best_in_table_q;
	logic          any_usable_q;
	logic          any_sendable_q;

	logic [IW-1:0] idx_q;
	logic          do_upd_q;
	logic          new_q;
	logic [CW-1:0] scan_q;
	logic [CW-1:0] kept_q;

	logic          result_valid_q;
	swrr_pkg::result_t result_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [WW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [WW-1:0] ram_rdata;

	// lookup
	logic          usable;
	logic          hit;
	logic [IW-1:0] hit_idx;
	logic          full;
	logic [15:0]   w_eff;

	// accrue
	logic [WW-1:0] cur_w;
	logic [WW:0]   acc_sum;
	logic [WW-1:0] new_w;
	logic [TW:0]   tot_sum;
	logic [TW-1:0] new_total;
	logic          take_data;

	// compaction
	logic [WW:0]   sub_sum;
	logic [WW-1:0] sub_w;
	logic [IW-1:0] scan_idx;
	logic [IW-1:0] kept_idx;

	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == swrr_pkg::REG_TIMEOUT_THR);
	assign prdata = (paddr[2] == swrr_pkg::REG_TIMEOUT_THR) ?
		{{(32-swrr_pkg::THR_W){1'b0}}, thr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= swrr_pkg::THR_RESET;
		end else if (cfg_wr) begin
			thr_q <= pwdata[swrr_pkg::THR_W-1:0];
		end
	end

	assign item_ready = (state_q == swrr_pkg::ST_IDLE);
	assign result_valid = result_valid_q;
	assign result = result_q;
	assign w_eff = (item_q.weight == 16'd0) ? 16'd1 : item_q.weight;
	assign scan_idx = scan_q[IW-1:0];
	assign kept_idx = kept_q[IW-1:0];

	always_comb begin
		usable = item_q.path_active && !item_q.path_frozen && !item_q.socket_error &&
			(item_q.timeout_count < thr_q) &&
			!(item_q.reinject && (item_q.path_id == item_q.packet_path_id));
		hit = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (!hit && (CW'(i) < count_q) && (pid_q[i] == item_q.path_id)) begin
				hit = 1'b1;
				hit_idx = IW'(i);
			end
		end
		full = (count_q == CW'(N));
	end

	always_comb begin
		cur_w = new_q ? '0 : ram_rdata;
		acc_sum = {cur_w[WW-1], cur_w} + {{(WW-15){1'b0}}, w_eff};
		if (acc_sum[WW:WW-1] == 2'b01) begin
			new_w = {1'b0, {(WW-1){1'b1}}};
		end else begin
			new_w = acc_sum[WW-1:0];
		end
		tot_sum = {1'b0, total_q} + {{(TW-15){1'b0}}, w_eff};
		new_total = tot_sum[TW] ? {TW{1'b1}} : tot_sum[TW-1:0];
		take_data = !best_found_q || !best_in_table_q ||
			((idx_q != best_slot_q) && ($signed(new_w) > $signed(best_weight_q)));
		sub_sum = {best_weight_q[WW-1], best_weight_q} - {{(WW-TW+1){1'b0}}, total_q};
		if (sub_sum[WW:WW-1] == 2'b10) begin
			sub_w = {1'b1, {(WW-1){1'b0}}};
		end else begin
			sub_w = sub_sum[WW-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = new_w;
		ram_raddr = hit ? hit_idx : count_q[IW-1:0];
		unique case (state_q)
			swrr_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = swrr_pkg::ST_LOOK;
				end
			end
			swrr_pkg::ST_LOOK: begin
				state_d = swrr_pkg::ST_UPD;
			end
			swrr_pkg::ST_UPD: begin
				ram_we = do_upd_q;
				if (!item_q.last_path) begin
					state_d = swrr_pkg::ST_IDLE;
				end else if (item_q.control_packet) begin
					state_d = swrr_pkg::ST_EMIT;
				end else begin
					state_d = swrr_pkg::ST_CRD;
				end
			end
			swrr_pkg::ST_CRD: begin
				ram_raddr = scan_idx;
				state_d = (scan_q == count_q) ? swrr_pkg::ST_EMIT : swrr_pkg::ST_CWR;
			end
			swrr_pkg::ST_CWR: begin
				ram_we = seen_q[scan_idx];
				ram_waddr = kept_idx;
				ram_wdata = (best_found_q && best_in_table_q && (scan_idx == best_slot_q)) ?
					sub_w : ram_rdata;
				state_d = swrr_pkg::ST_CRD;
			end
			swrr_pkg::ST_EMIT: begin
				if (!result_valid_q || result_ready) begin
					state_d = swrr_pkg::ST_IDLE;
				end
			end
			default: state_d = swrr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swrr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	swrr_ram #(
		.WIDTH(WW),
		.DEPTH(N)
	) u_weight_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		if (state_q == swrr_pkg::ST_LOOK) begin
			idx_q <= hit ? hit_idx : count_q[IW-1:0];
			new_q <= !hit;
			if (usable && !item_q.control_packet && !hit && !full) begin
				pid_q[count_q[IW-1:0]] <= item_q.path_id;
			end
		end
		if ((state_q == swrr_pkg::ST_CWR) && seen_q[scan_idx]) begin
			pid_q[kept_idx] <= pid_q[scan_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			count_q <= '0;
			total_q <= '0;
			best_slot_q <= '0;
			best_path_q <= '0;
			best_found_q <= 1'b0;
			best_rtt_q <= '1;
			best_weight_q <= '0;
			best_in_table_q <= 1'b0;
			any_usable_q <= 1'b0;
			any_sendable_q <= 1'b0;
			do_upd_q <= 1'b0;
			scan_q <= '0;
			kept_q <= '0;
			result_valid_q <= 1'b0;
			result_q <= '0;
		end else begin
			if (result_valid_q && result_ready && (state_q != swrr_pkg::ST_EMIT)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				swrr_pkg::ST_LOOK: begin
					do_upd_q <= usable && !item_q.control_packet && (hit || !full);
					if (usable) begin
						any_usable_q <= 1'b1;
						if (item_q.control_packet) begin
							if (item_q.can_send) begin
								any_sendable_q <= 1'b1;
								if (!best_found_q || (item_q.smoothed_rtt < best_rtt_q)) begin
									best_rtt_q <= item_q.smoothed_rtt;
									best_path_q <= item_q.path_id;
									best_found_q <= 1'b1;
									best_in_table_q <= 1'b0;
								end
							end
						end else if (!hit && !full) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				swrr_pkg::ST_UPD: begin
					scan_q <= '0;
					kept_q <= '0;
					if (do_upd_q) begin
						seen_q[idx_q] <= 1'b1;
						total_q <= new_total;
						if (best_in_table_q && (idx_q == best_slot_q)) begin
							best_weight_q <= new_w;
						end
						if (item_q.can_send) begin
							any_sendable_q <= 1'b1;
							if (take_data) begin
								best_slot_q <= idx_q;
								best_path_q <= item_q.path_id;
								best_found_q <= 1'b1;
								best_in_table_q <= 1'b1;
								best_weight_q <= new_w;
							end
						end
					end
				end
				swrr_pkg::ST_CRD: begin
					if (scan_q == count_q) begin
						count_q <= kept_q;
					end
				end
				swrr_pkg::ST_CWR: begin
					scan_q <= scan_q + CW'(1);
					if (seen_q[scan_idx]) begin
						kept_q <= kept_q + CW'(1);
					end
				end
				swrr_pkg::ST_EMIT: begin
					if (!result_valid_q || result_ready) begin
						result_valid_q <= 1'b1;
						result_q.selected_valid <= best_found_q;
						result_q.selected_path_id <= best_found_q ? best_path_q : 8'd0;
						result_q.send_blocked <= any_usable_q && !any_sendable_q;
						seen_q <= '0;
						total_q <= '0;
						best_slot_q <= '0;
						best_path_q <= '0;
						best_found_q <= 1'b0;
						best_rtt_q <= '1;
						best_in_table_q <= 1'b0;
						any_usable_q <= 1'b0;
						any_sendable_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ verif/tb.sv @@
// Testbench for smooth_weighted_round_robin_path_select: random and directed selection passes,
// in-bench prediction of the weighted table and min-rtt rule, results checked in order.
// Depends on swrr_pkg and the block's RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ADDR_THR = {swrr_pkg::REG_TIMEOUT_THR, 2'b00};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	swrr_pkg::item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	swrr_pkg::result_t result;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	smooth_weighted_round_robin_path_select dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

	// predictor state
	logic [7:0] tbl_pid [swrr_pkg::MAX_PATHS];
	logic signed [31:0] tbl_cw [swrr_pkg::MAX_PATHS];
	bit tbl_seen [swrr_pkg::MAX_PATHS];
	int tbl_cnt;
	int unsigned tot;
	int b_slot;
	logic [7:0] b_path;
	bit b_found, b_tbl, any_use, any_send;
	logic [31:0] b_rtt;
	logic [3:0] thr;

	swrr_pkg::item_t pending_items[$];
	swrr_pkg::result_t expected_sel[$];
	int errors = 0;
	int send_idle = 0, recv_idle = 0;

	function automatic logic signed [31:0] sat(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic void clear_scratch();
		foreach (tbl_seen[i]) tbl_seen[i] = 0;
		tot = 0; b_slot = 0; b_path = 0; b_found = 0; b_rtt = '1;
		any_use = 0; any_send = 0; b_tbl = 0;
	endfunction

	function automatic void predict_select(swrr_pkg::item_t it);
		int unsigned w;
		bit ok, hit;
		int i, kept;
		swrr_pkg::result_t r;
		w = (it.weight == 0) ? 1 : it.weight;
		ok = it.path_active && !it.path_frozen && !it.socket_error &&
			it.timeout_count < thr && !(it.reinject && it.path_id == it.packet_path_id);
		hit = 0;
		if (ok) begin
			any_use = 1;
			if (it.control_packet) begin
				if (it.can_send) begin
					any_send = 1;
					if (!b_found || it.smoothed_rtt < b_rtt) begin
						b_rtt = it.smoothed_rtt; b_path = it.path_id;
						b_found = 1; b_tbl = 0;
					end
				end
			end else begin
				for (i = 0; i < tbl_cnt; i++)
					if (tbl_pid[i] == it.path_id) begin
						hit = 1;
						break;
					end
				if (!hit && tbl_cnt < swrr_pkg::MAX_PATHS) begin
					i = tbl_cnt;
					tbl_pid[i] = it.path_id; tbl_cw[i] = 0; tbl_seen[i] = 0;
					tbl_cnt++;
					hit = 1;
				end
				if (hit) begin
					tbl_seen[i] = 1;
					tbl_cw[i] = sat(longint'(tbl_cw[i]) + longint'(w));
					tot = tot + w;
					if (tot > 24'hffffff) tot = 24'hffffff;
					if (it.can_send) begin
						any_send = 1;
						if (!b_found || !b_tbl || tbl_cw[i] > tbl_cw[b_slot]) begin
							b_slot = i; b_path = it.path_id; b_found = 1; b_tbl = 1;
						end
					end
				end
			end
		end
		if (!it.last_path) return;
		if (!it.control_packet) begin
			if (b_found && b_tbl)
				tbl_cw[b_slot] = sat(longint'(tbl_cw[b_slot]) - longint'(tot));
			kept = 0;
			for (i = 0; i < tbl_cnt; i++)
				if (tbl_seen[i]) begin
					tbl_pid[kept] = tbl_pid[i]; tbl_cw[kept] = tbl_cw[i];
					tbl_seen[kept] = 1; kept++;
				end
			tbl_cnt = kept;
		end
		r.selected_valid = b_found;
		r.selected_path_id = b_found ? b_path : 8'd0;
		r.send_blocked = any_use && !any_send;
		expected_sel.push_back(r);
		clear_scratch();
	endfunction

	// accepted flag latched at the rising edge, used by the driver at the falling edge
	logic item_ready_q = 1'b0;
	always @(posedge clk) begin
		item_ready_q <= item_valid && item_ready;
		if (item_valid && item_ready) predict_select(item);
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || item_ready_q) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
			result_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			if (expected_sel.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				errors++;
			end else begin
				swrr_pkg::result_t e;
				e = expected_sel.pop_front();
				if (result.selected_valid !== e.selected_valid ||
					result.selected_path_id !== e.selected_path_id ||
					result.send_blocked !== e.send_blocked) begin
					$display("%0t: mismatch expected %p actual %p", $time, e, result);
					errors++;
				end
			end
		end
	end

	task automatic write_thr(input logic [3:0] v);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_THR; pwdata <= {28'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		thr = v;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || item_valid || expected_sel.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic swrr_pkg::item_t rand_path(bit ctrl, bit last, logic [7:0] pid);
		swrr_pkg::item_t it;
		it.path_id = pid;
		case ($urandom_range(3))
			0: it.weight = 16'($urandom);
			1: it.weight = 16'hffff;
			default: it.weight = 16'($urandom_range(10));
		endcase
		it.path_active = ($urandom_range(9) != 0);
		it.path_frozen = ($urandom_range(9) == 0);
		it.socket_error = ($urandom_range(9) == 0);
		it.timeout_count = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(2));
		it.can_send = ($urandom_range(4) != 0);
		it.smoothed_rtt = ($urandom_range(1)) ? $urandom : $urandom_range(20);
		it.control_packet = ctrl;
		it.reinject = ($urandom_range(5) == 0);
		it.packet_path_id = $urandom_range(1) ? pid : 8'($urandom);
		it.last_path = last;
		return it;
	endfunction

	task automatic add_pass(int n, bit mixed);
		bit ctrl;
		int k;
		ctrl = ($urandom_range(4) == 0);
		for (k = 0; k < n; k++) begin
			logic [7:0] pid;
			pid = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(11));
			pending_items.push_back(rand_path(mixed ? bit'($urandom_range(1)) : ctrl,
				k == n - 1, pid));
		end
	endtask

	task automatic add_random(int count);
		int added;
		added = 0;
		while (added < count) begin
			int n;
			n = $urandom_range(1, 10);
			add_pass(n, $urandom_range(9) == 0);
			added += n;
		end
	endtask

	initial begin
		swrr_pkg::item_t it;
		thr = swrr_pkg::THR_RESET;
		clear_scratch();
		tbl_cnt = 0;
		foreach (tbl_cw[i]) begin
			tbl_cw[i] = 0;
			tbl_pid[i] = 0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle = 19; recv_idle = 51;

		// directed: extremes, full table, control, mixed, reinject, none usable
		it = '0;
		it.path_active = 1; it.can_send = 1;
		for (int k = 0; k < 10; k++) begin
			it.path_id = (k == 9) ? 8'hff : 8'(k);
			it.weight = (k < 5) ? 16'hffff : 16'h0;
			it.last_path = (k == 9);
			it.packet_path_id = 8'hff; it.reinject = (k == 9);
			pending_items.push_back(it);
		end
		it = '1;
		it.path_frozen = 0; it.socket_error = 0; it.timeout_count = 0; it.reinject = 0;
		it.last_path = 1;
		pending_items.push_back(it);
		it.smoothed_rtt = 0; it.path_id = 8'd0; it.last_path = 0;
		pending_items.push_back(it);
		it.control_packet = 0; it.last_path = 1;
		pending_items.push_back(it);
		it = '0; it.path_frozen = 1; it.socket_error = 1; it.timeout_count = 4'hf;
		it.last_path = 1;
		pending_items.push_back(it);
		it = '0; it.path_active = 1; it.last_path = 1;
		pending_items.push_back(it);
		for (int k = 0; k < 4; k++) add_pass(4, 1);
		drain();

		write_thr(4'd0);
		add_random(60);
		drain();
		write_thr(4'hf);
		add_random(500);
		drain();
		send_idle = 51; recv_idle = 19;
		write_thr(4'd3);
		add_random(500);
		drain();
		send_idle = 0; recv_idle = 0;
		write_thr(4'd8);
		add_random(450);
		drain();

		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule

@@ sim.f @@
hdl/swrr_pkg.sv
hdl/swrr_ram.sv
hdl/smooth_weighted_round_robin_path_select.sv
verif/tb.sv
